FILE: hw/rtl/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

  // Sync pair that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'h40;  // '@'
  localparam logic [7:0] SYNC_SECOND = 8'h54;  // 'T'

  // Serial numbers follow each other modulo this value
  localparam int SERIAL_MOD = 'h80;

  localparam int MAX_PAYLOAD_DEF = 2048;
  localparam logic [15:0] MIN_VERSION_RESET = 16'd1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_HEADER  = 1'b1;

  // Bit positions in the status flag vector
  localparam int FLAG_VERSION  = 0;
  localparam int FLAG_LOST     = 1;
  localparam int FLAG_CHECKSUM = 2;
  localparam int FLAG_W        = 3;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] sender_version;
    logic [11:0] payload_length;
    logic [7:0]  frame_serial;
    logic [15:0] feature_address;
    logic [7:0]  request_byte;
    logic [7:0]  mode_byte;
    logic        version_error;
    logic        lost_frames;
    logic        checksum_unverified;
  } cfd_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cfd_byte_if.sv
`default_nettype none

interface cfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cfd_frame_if.sv
`default_nettype none

interface cfd_frame_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [15:0] sender_version;
  logic [11:0] payload_length;
  logic [7:0]  frame_serial;
  logic [15:0] feature_address;
  logic [7:0]  request_byte;
  logic [7:0]  mode_byte;
  logic        version_error;
  logic        lost_frames;
  logic        checksum_unverified;

  modport source (
    output valid, input ready,
    output item_kind, output payload_byte, output sender_version, output payload_length,
    output frame_serial, output feature_address, output request_byte, output mode_byte,
    output version_error, output lost_frames, output checksum_unverified
  );
  modport sink (
    input valid, output ready,
    input item_kind, input payload_byte, input sender_version, input payload_length,
    input frame_serial, input feature_address, input request_byte, input mode_byte,
    input version_error, input lost_frames, input checksum_unverified
  );
endinterface

`default_nettype wire

FILE: hw/rtl/cfd_cfg_if.sv
`default_nettype none

interface cfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cfd_parser.sv
`default_nettype none

// Frame parse state machine. One byte per step; result built from the
// next-state values so a header carries fields written in the same step.
module cfd_parser #(
  parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  wire  [7:0]           rx_byte,
  input  wire  [15:0]          min_version,
  output logic                 has_result,
  output cfd_pkg::cfd_result_t result
);
  import cfd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_SYNC2   = 4'd1;
  localparam logic [3:0] POS_VER_LO  = 4'd2;
  localparam logic [3:0] POS_VER_HI  = 4'd3;
  localparam logic [3:0] POS_LEN_LO  = 4'd4;
  localparam logic [3:0] POS_LEN_HI  = 4'd5;
  localparam logic [3:0] POS_SERIAL  = 4'd6;
  localparam logic [3:0] POS_FEAT_LO = 4'd7;
  localparam logic [3:0] POS_FEAT_HI = 4'd8;
  localparam logic [3:0] POS_REQUEST = 4'd9;
  localparam logic [3:0] POS_MODE    = 4'd10;
  localparam logic [3:0] POS_PAYLOAD = 4'd11;
  localparam logic [3:0] POS_CSUM0   = 4'd12;
  localparam logic [3:0] POS_CSUM1   = 4'd13;
  localparam logic [3:0] POS_CSUM2   = 4'd14;
  localparam logic [3:0] POS_CSUM3   = 4'd15;

  logic [3:0]        pos, pos_next;
  logic [15:0]       held_version, held_version_next;
  logic [15:0]       held_length, held_length_next;
  logic [7:0]        held_serial, held_serial_next;
  logic [7:0]        prev_serial, prev_serial_next;
  logic              first_frame, first_frame_next;
  logic [15:0]       held_feature, held_feature_next;
  logic [7:0]        held_request, held_request_next;
  logic [7:0]        held_mode, held_mode_next;
  logic [CNT_W-1:0]  payload_count, payload_count_next;
  logic [CNT_W-1:0]  count_inc;
  logic [FLAG_W-1:0] flags, flags_next;
  logic [7:0]        serial_expect;
  logic              emit_header, emit_payload;
  logic [7:0]        header_byte;

  assign count_inc     = payload_count + CNT_W'(1);
  assign serial_expect = {1'b0, prev_serial[6:0] + 7'd1};

  always_comb begin
    pos_next           = pos;
    held_version_next  = held_version;
    held_length_next   = held_length;
    held_serial_next   = held_serial;
    prev_serial_next   = prev_serial;
    first_frame_next   = first_frame;
    held_feature_next  = held_feature;
    held_request_next  = held_request;
    held_mode_next     = held_mode;
    payload_count_next = payload_count;
    flags_next         = flags;
    emit_header        = 1'b0;
    emit_payload       = 1'b0;
    header_byte        = 8'd0;

    unique case (pos)
      POS_HUNT: begin
        flags_next = '0;
        if (rx_byte == SYNC_FIRST) pos_next = POS_SYNC2;
      end
      POS_SYNC2: pos_next = (rx_byte == SYNC_SECOND) ? POS_VER_LO : POS_HUNT;
      POS_VER_LO: begin
        held_version_next = {8'd0, rx_byte};
        pos_next = POS_VER_HI;
      end
      POS_VER_HI: begin
        held_version_next = {rx_byte, held_version[7:0]};
        if (held_version_next < min_version) flags_next[FLAG_VERSION] = 1'b1;
        pos_next = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        held_length_next = {8'd0, rx_byte};
        pos_next = POS_LEN_HI;
      end
      POS_LEN_HI: begin
        held_length_next = {rx_byte, held_length[7:0]};
        // oversize frame: back to hunt, nothing reported
        pos_next = (held_length_next > MAX_LEN) ? POS_HUNT : POS_SERIAL;
      end
      POS_SERIAL: begin
        held_serial_next = rx_byte;
        if (first_frame) begin
          first_frame_next = 1'b0;
        end else if (rx_byte != serial_expect) begin
          flags_next[FLAG_LOST] = 1'b1;
        end
        prev_serial_next = rx_byte;
        pos_next = POS_FEAT_LO;
      end
      POS_FEAT_LO: begin
        held_feature_next = {8'd0, rx_byte};
        pos_next = POS_FEAT_HI;
      end
      POS_FEAT_HI: begin
        held_feature_next = {rx_byte, held_feature[7:0]};
        pos_next = POS_REQUEST;
      end
      POS_REQUEST: begin
        held_request_next = rx_byte;
        pos_next = POS_MODE;
      end
      POS_MODE: begin
        held_mode_next = rx_byte;
        if (held_length != 16'd0) begin
          payload_count_next = '0;
          pos_next = POS_PAYLOAD;
        end else if (rx_byte[0]) begin
          pos_next = POS_CSUM0;
        end else begin
          emit_header = 1'b1;
          pos_next = POS_HUNT;
        end
      end
      POS_PAYLOAD: begin
        payload_count_next = count_inc;
        if (16'(count_inc) >= held_length) begin
          if (held_mode[0]) begin
            emit_payload = 1'b1;
            pos_next = POS_CSUM0;
          end else begin
            // last payload byte rides in the header
            emit_header = 1'b1;
            header_byte = rx_byte;
            pos_next = POS_HUNT;
          end
        end else begin
          emit_payload = 1'b1;
        end
      end
      POS_CSUM0: pos_next = POS_CSUM1;
      POS_CSUM1: pos_next = POS_CSUM2;
      POS_CSUM2: pos_next = POS_CSUM3;
      POS_CSUM3: begin
        flags_next[FLAG_CHECKSUM] = 1'b1;
        emit_header = 1'b1;
        pos_next = POS_HUNT;
      end
    endcase
  end

  always_comb begin
    result = '0;
    if (emit_header) begin
      result.item_kind           = KIND_HEADER;
      result.payload_byte        = header_byte;
      result.sender_version      = held_version_next;
      result.payload_length      = held_length_next[11:0];
      result.frame_serial        = held_serial_next;
      result.feature_address     = held_feature_next;
      result.request_byte        = held_request_next;
      result.mode_byte           = held_mode_next;
      result.version_error       = flags_next[FLAG_VERSION];
      result.lost_frames         = flags_next[FLAG_LOST];
      result.checksum_unverified = flags_next[FLAG_CHECKSUM];
    end else if (emit_payload) begin
      result.item_kind    = KIND_PAYLOAD;
      result.payload_byte = rx_byte;
    end
  end

  assign has_result = emit_header || emit_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HUNT;
      first_frame <= 1'b1;
      flags       <= '0;
    end else if (step) begin
      pos         <= pos_next;
      first_frame <= first_frame_next;
      flags       <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_version  <= held_version_next;
      held_length   <= held_length_next;
      held_serial   <= held_serial_next;
      prev_serial   <= prev_serial_next;
      held_feature  <= held_feature_next;
      held_request  <= held_request_next;
      held_mode     <= held_mode_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/command_frame_deframer_unit.sv
// Command frame deframer.
// byte_in:   one received byte per request (valid/ready). The stream is
//            hunted for the sync pair '@' 'T', then header fields, payload
//            and an optional four-byte checksum are consumed.
// frame_out: one result per payload byte (item_kind 0) and one header
//            result (item_kind 1) closing each frame, with the error flags.
//            A frame whose last payload byte ends it gives only the header,
//            which then carries that byte in payload_byte.
// cfg:       writes min_sender_version; always ready. Write only while idle.
// Timing: input register, parse logic, result register. Each accepted
//   byte's result is held in the result register. Sustained rate is one
//   byte per cycle unless frame_out stalls; parse state moves once per byte.
// Stall: while a result waits, the input register still holds one byte;
//   byte_in.ready drops only when both registers are full and
//   frame_out.ready is low. Nothing is lost or repeated.
// Reset: parser back to hunting, first-frame serial check off, flags
//   clear, both registers empty, min_sender_version = 1.
`default_nettype none

module command_frame_deframer_unit #(
  parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
  input wire         clk,
  input wire         rst,
  cfd_byte_if.sink   byte_in,
  cfd_frame_if.source frame_out,
  cfd_cfg_if.sink    cfg
);
  import cfd_pkg::*;

  logic [15:0] min_ver;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        res_valid;
  cfd_result_t res;
  logic        out_free;
  logic        step;
  logic        has_result;
  cfd_result_t result;

  // config register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_ver <= MIN_VERSION_RESET;
    end else if (cfg.valid) begin
      min_ver <= cfg.data;
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free      = !res_valid || frame_out.ready;
  assign step          = in_valid && out_free;
  assign byte_in.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) in_byte <= byte_in.rx_byte;
  end

  cfd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (in_byte),
    .min_version(min_ver),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= step && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && has_result) res <= result;
  end

  assign frame_out.valid               = res_valid;
  assign frame_out.item_kind           = res.item_kind;
  assign frame_out.payload_byte        = res.payload_byte;
  assign frame_out.sender_version      = res.sender_version;
  assign frame_out.payload_length      = res.payload_length;
  assign frame_out.frame_serial        = res.frame_serial;
  assign frame_out.feature_address     = res.feature_address;
  assign frame_out.request_byte        = res.request_byte;
  assign frame_out.mode_byte           = res.mode_byte;
  assign frame_out.version_error       = res.version_error;
  assign frame_out.lost_frames         = res.lost_frames;
  assign frame_out.checksum_unverified = res.checksum_unverified;

  // a full pipeline with a stalled receiver must refuse input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && res_valid && !frame_out.ready |-> !byte_in.ready)
    else $error("input accepted while both stages are full");

  // payload results carry nothing but the byte
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    frame_out.valid && frame_out.item_kind == KIND_PAYLOAD |->
      frame_out.sender_version == 16'd0 && frame_out.mode_byte == 8'd0 &&
      !frame_out.version_error && !frame_out.lost_frames &&
      !frame_out.checksum_unverified)
    else $error("payload result with header fields set");

  // checksum flag only on frames whose mode announces a checksum
  a_csum_mode: assert property (@(posedge clk) disable iff (rst)
    frame_out.valid && frame_out.item_kind == KIND_HEADER &&
      frame_out.checksum_unverified |-> frame_out.mode_byte[0])
    else $error("checksum flag without checksum mode");

  // result register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !frame_out.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

FILE: bench/cfd_checker.sv
`timescale 1ns / 1ps

// Watches the byte, result and register channels of the deframer, keeps its own
// copy of the frame parser and compares every result against the oldest one due.
module cfd_checker #(
  parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
  input wire   clk,
  input wire   rst,
  cfd_byte_if  byte_mon,
  cfd_frame_if frame_mon,
  cfd_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  import cfd_pkg::*;

  typedef enum logic [3:0] {
    P_HUNT, P_SYNC2, P_VER_LO, P_VER_HI, P_LEN_LO, P_LEN_HI, P_SERIAL, P_FEAT_LO,
    P_FEAT_HI, P_REQUEST, P_MODE, P_PAYLOAD, P_CSUM0, P_CSUM1, P_CSUM2, P_CSUM3
  } parse_pos_t;

  parse_pos_t          pos;
  logic [15:0]         min_version;
  logic [15:0]         hdr_version;
  logic [15:0]         hdr_length;
  logic [7:0]          hdr_serial;
  logic [7:0]          prior_serial;
  logic                first_seen;
  logic [15:0]         hdr_feature;
  logic [7:0]          hdr_request;
  logic [7:0]          hdr_mode;
  logic [15:0]         bytes_in_payload;
  logic [FLAG_W-1:0]   flags;
  cfd_result_t         results_due[$];
  cfd_result_t         got;
  cfd_result_t         want;

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  // One byte through the parser; queues the result it causes, if any.
  task automatic parse_byte(input logic [7:0] b);
    cfd_result_t r;
    logic        give_header;
    logic        give_payload;
    logic [7:0]  last_byte;
    r = '0;
    give_header = 1'b0;
    give_payload = 1'b0;
    last_byte = 8'h00;
    case (pos)
      P_HUNT: begin
        flags = '0;
        if (b == SYNC_FIRST) pos = P_SYNC2;
      end
      P_SYNC2: pos = (b == SYNC_SECOND) ? P_VER_LO : P_HUNT;
      P_VER_LO: begin
        hdr_version = {8'h00, b};
        pos = P_VER_HI;
      end
      P_VER_HI: begin
        hdr_version = {b, hdr_version[7:0]};
        if (hdr_version < min_version) flags[FLAG_VERSION] = 1'b1;
        pos = P_LEN_LO;
      end
      P_LEN_LO: begin
        hdr_length = {8'h00, b};
        pos = P_LEN_HI;
      end
      P_LEN_HI: begin
        hdr_length = {b, hdr_length[7:0]};
        pos = (int'(hdr_length) > MAX_PAYLOAD) ? P_HUNT : P_SERIAL;
      end
      P_SERIAL: begin
        hdr_serial = b;
        if (first_seen) first_seen = 1'b0;
        else if (int'(b) != (int'(prior_serial) + 1) % SERIAL_MOD) flags[FLAG_LOST] = 1'b1;
        prior_serial = b;
        pos = P_FEAT_LO;
      end
      P_FEAT_LO: begin
        hdr_feature = {8'h00, b};
        pos = P_FEAT_HI;
      end
      P_FEAT_HI: begin
        hdr_feature = {b, hdr_feature[7:0]};
        pos = P_REQUEST;
      end
      P_REQUEST: begin
        hdr_request = b;
        pos = P_MODE;
      end
      P_MODE: begin
        hdr_mode = b;
        if (hdr_length != 16'd0) begin
          bytes_in_payload = '0;
          pos = P_PAYLOAD;
        end else if (b[0]) begin
          pos = P_CSUM0;
        end else begin
          give_header = 1'b1;
        end
      end
      P_PAYLOAD: begin
        bytes_in_payload = bytes_in_payload + 16'd1;
        if (bytes_in_payload >= hdr_length && !hdr_mode[0]) begin
          // last payload byte rides in the header
          give_header = 1'b1;
          last_byte = b;
        end else begin
          if (bytes_in_payload >= hdr_length) pos = P_CSUM0;
          give_payload = 1'b1;
        end
      end
      P_CSUM0, P_CSUM1, P_CSUM2: pos = parse_pos_t'(pos + 4'd1);
      default: begin
        flags[FLAG_CHECKSUM] = 1'b1;
        give_header = 1'b1;
      end
    endcase
    if (give_header) begin
      r.item_kind           = KIND_HEADER;
      r.payload_byte        = last_byte;
      r.sender_version      = hdr_version;
      r.payload_length      = hdr_length[11:0];
      r.frame_serial        = hdr_serial;
      r.feature_address     = hdr_feature;
      r.request_byte        = hdr_request;
      r.mode_byte           = hdr_mode;
      r.version_error       = flags[FLAG_VERSION];
      r.lost_frames         = flags[FLAG_LOST];
      r.checksum_unverified = flags[FLAG_CHECKSUM];
      pos = P_HUNT;
      results_due.push_back(r);
    end
    if (give_payload) begin
      r.item_kind    = KIND_PAYLOAD;
      r.payload_byte = b;
      results_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos = P_HUNT;
      min_version = MIN_VERSION_RESET;
      hdr_version = '0;
      hdr_length = '0;
      hdr_serial = '0;
      prior_serial = '0;
      first_seen = 1'b1;
      hdr_feature = '0;
      hdr_request = '0;
      hdr_mode = '0;
      bytes_in_payload = '0;
      flags = '0;
      results_due.delete();
    end else begin
      // results leave after the input and result registers, so compare first
      if (frame_mon.valid && frame_mon.ready) begin
        got.item_kind           = frame_mon.item_kind;
        got.payload_byte        = frame_mon.payload_byte;
        got.sender_version      = frame_mon.sender_version;
        got.payload_length      = frame_mon.payload_length;
        got.frame_serial        = frame_mon.frame_serial;
        got.feature_address     = frame_mon.feature_address;
        got.request_byte        = frame_mon.request_byte;
        got.mode_byte           = frame_mon.mode_byte;
        got.version_error       = frame_mon.version_error;
        got.lost_frames         = frame_mon.lost_frames;
        got.checksum_unverified = frame_mon.checksum_unverified;
        if (results_due.size() == 0) begin
          $error("result with none due: kind %0b byte %0h", got.item_kind, got.payload_byte);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("item_kind", want.item_kind, got.item_kind);
          check_field("payload_byte", want.payload_byte, got.payload_byte);
          check_field("sender_version", want.sender_version, got.sender_version);
          check_field("payload_length", want.payload_length, got.payload_length);
          check_field("frame_serial", want.frame_serial, got.frame_serial);
          check_field("feature_address", want.feature_address, got.feature_address);
          check_field("request_byte", want.request_byte, got.request_byte);
          check_field("mode_byte", want.mode_byte, got.mode_byte);
          check_field("version_error", want.version_error, got.version_error);
          check_field("lost_frames", want.lost_frames, got.lost_frames);
          check_field("checksum_unverified", want.checksum_unverified,
                      got.checksum_unverified);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) min_version = cfg_mon.data;
      if (byte_mon.valid && byte_mon.ready) parse_byte(byte_mon.rx_byte);
    end
    pending = results_due.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cfd_pkg::*;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          pending;

  // Handshake seen at the last rising edge, read back at the falling edge.
  logic        byte_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        out_ready = 1'b0;
  // While set, neither side idles.
  logic        calm = 1'b0;

  int          bytes_sent;
  logic [7:0]  serial_next;
  logic [15:0] min_cur;

  cfd_byte_if  byte_if ();
  cfd_frame_if frame_if ();
  cfd_cfg_if   cfg_if ();

  assign frame_if.ready = out_ready;

  command_frame_deframer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_if),
    .frame_out (frame_if),
    .cfg       (cfg_if)
  );

  cfd_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .byte_mon   (byte_if),
    .frame_mon  (frame_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample handshakes at the edge they happen on; the driver acts on them
  // at the next falling edge.
  always @(posedge clk) begin
    byte_taken <= byte_if.valid && byte_if.ready;
    cfg_taken  <= cfg_if.valid && cfg_if.ready;
  end

  // Result side: stalls at random, about 7 percent of the time, unless calm.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  // Called at a falling edge; returns at the falling edge after acceptance,
  // with valid still high so back-to-back requests need no extra drive.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 7) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    do @(negedge clk); while (!byte_taken);
    bytes_sent++;
  endtask

  // Full frame. An oversized length makes the parser drop back to the hunt,
  // so the rest of the frame is not sent.
  task automatic send_frame(input logic [15:0] ver, input logic [15:0] len,
                            input logic [7:0] ser, input logic [15:0] feat,
                            input logic [7:0] req, input logic [7:0] mode);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(ver[7:0]);
    send_byte(ver[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (int'(len) > MAX_PAYLOAD_DEF) return;
    send_byte(ser);
    send_byte(feat[7:0]);
    send_byte(feat[15:8]);
    send_byte(req);
    send_byte(mode);
    repeat (len) send_byte(8'($urandom));
    if (mode[0]) repeat (4) send_byte(8'($urandom));
  endtask

  // Register write only with the block idle: all results in, then a wait
  // so a byte with no result clears both pipeline registers.
  task automatic write_min_version(input logic [15:0] v);
    byte_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(negedge clk); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
    min_cur = v;
  endtask

  // Well-formed frame with random content; version lands around the
  // threshold, serial mostly in sequence, lengths mostly short.
  task automatic random_frame();
    logic [15:0] ver;
    logic [15:0] len;
    logic [7:0]  ser;
    int          pick;
    pick = $urandom_range(3);
    case (pick)
      0: ver = min_cur;
      1: ver = min_cur - 16'd1;
      2: ver = 16'($urandom);
      default: ver = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    pick = $urandom_range(99);
    if (pick < 5) len = 16'($urandom_range(65535, MAX_PAYLOAD_DEF + 1));
    else if (pick < 12) len = 16'd0;
    else if (pick < 90) len = 16'($urandom_range(8, 1));
    else len = 16'($urandom_range(40, 9));
    ser = ($urandom_range(99) < 80) ? serial_next : 8'($urandom);
    if (int'(len) <= MAX_PAYLOAD_DEF) serial_next = 8'((int'(ser) + 1) % SERIAL_MOD);
    send_frame(ver, len, ser, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Mostly frames; the rest is line noise, broken sync pairs and headers
  // cut short so the following bytes get parsed as fields.
  task automatic random_traffic(input int n_bytes);
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 76) begin
        random_frame();
      end else if (pick < 86) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else if (pick < 93) begin
        send_byte(SYNC_FIRST);
        send_byte(8'($urandom));
      end else begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.rx_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.data = 16'h0000;
    bytes_sent = 0;
    serial_next = 8'h00;
    min_cur = MIN_VERSION_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, threshold still at its reset value.
    // Noise while hunting, '@' '@' 'T' and '@' then a wrong byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h55);
    // Empty frame, version below threshold, first serial unchecked.
    send_frame(16'h0000, 16'd0, 8'h7F, 16'h0000, 8'h00, 8'h00);
    // Empty frame with checksum; serial wraps 0x7F -> 0x00.
    send_frame(16'hFFFF, 16'd0, 8'h00, 16'hFFFF, 8'hFF, 8'h01);
    // Serial skips ahead; frame ends on its last payload byte.
    send_frame(16'h0001, 16'd3, 8'h05, 16'hA55A, 8'h12, 8'hFE);
    // One payload byte then checksum.
    send_frame(16'h0002, 16'd1, 8'h06, 16'h5AA5, 8'hED, 8'hFF);
    // Lengths over the limit are dropped without a result.
    send_frame(16'h1234, 16'd2049, 8'h07, 16'h0000, 8'h00, 8'h00);
    send_frame(16'h1234, 16'hFFFF, 8'h07, 16'h0000, 8'h00, 8'h00);
    // Longer payload; serial 0xFF is out of sequence.
    send_frame(16'h8000, 16'd64, 8'hFF, 16'h0001, 8'h80, 8'h00);
    // 0xFF + 1 modulo 0x80 is 0x00.
    send_frame(16'h0100, 16'd2, 8'h00, 16'h8000, 8'h01, 8'h00);
    serial_next = 8'h01;

    // Random phases at the extremes of the threshold and in between.
    write_min_version(16'h0000);
    random_traffic(260);
    write_min_version(16'hFFFF);
    calm = 1'b1;
    random_traffic(260);
    calm = 1'b0;
    write_min_version(16'($urandom_range(16'hFFFE, 2)));
    random_traffic(260);
    write_min_version(MIN_VERSION_RESET);
    random_traffic(260);

    // Drain: every due result in, then room for strays.
    byte_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
